@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the dispatcher RTL.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AST_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define AST_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/core/pcd_pkg.sv @@
// Package of the partitioned chunk dispatcher: codes, widths and shared types.
// Used by every module of the block; depends on nothing.
package pcd_pkg;

	localparam int LINE_BITS       = 16;
	localparam int MAX_PARTITIONS  = 16;
	localparam int PART_BITS       = 4;
	localparam int SEQ_DEPTH       = 16;
	localparam int SEQ_BITS        = 4;
	localparam int MAX_WORKERS_DEF = 64;

	// Input actions.
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_MSG   = 2'd2;

	// Message kinds.
	localparam logic [1:0] KIND_SETUP  = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;

	// Result commands.
	localparam logic [2:0] CMD_ASSIGN = 3'd0;
	localparam logic [2:0] CMD_SETUP  = 3'd1;
	localparam logic [2:0] CMD_EXIT   = 3'd2;
	localparam logic [2:0] CMD_ERROR  = 3'd3;
	localparam logic [2:0] CMD_ACK    = 3'd4;

	// Register indexes.
	localparam logic [2:0] REG_NUM_PARTITIONS  = 3'd0;
	localparam logic [2:0] REG_NUM_WORKERS     = 3'd1;
	localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd2;
	localparam logic [2:0] REG_MAX_CHUNK       = 3'd3;
	localparam logic [2:0] REG_CHUNK_MODE      = 3'd4;
	localparam logic [2:0] REG_SEQUENCE_LENGTH = 3'd5;

	// One entry of the partition store.
	typedef struct packed {
		logic [LINE_BITS-1:0] next_line;
		logic [LINE_BITS-1:0] end_line;
		logic                 exhausted;
	} part_ent_t;

	// Outcome of taking a chunk from a partition.
	typedef struct packed {
		logic [LINE_BITS-1:0] first;
		logic [LINE_BITS-1:0] last;
		logic [LINE_BITS-1:0] new_next;
		logic                 clipped;
	} take_res_t;

	// Status and quotients of the start divider.
	typedef struct packed {
		logic                 done;
		logic [LINE_BITS-1:0] quot_a;
		logic [LINE_BITS-1:0] quot_b;
	} div_res_t;

endpackage

@@ rtl/core/pcd_divider.sv @@
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on pcd_pkg for the line width and the result struct.
module pcd_divider import pcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [4:0]           divisor,
	input  logic [LINE_BITS-1:0] dividend_a,
	input  logic [LINE_BITS-1:0] dividend_b,
	output div_res_t             res
);

	localparam int CNT_BITS = $clog2(LINE_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [4:0]           dvs_q;
	logic [LINE_BITS-1:0] qa_q, qb_q;
	logic [4:0]           ra_q, rb_q;
	logic [5:0]           ta, tb;

	// Shift the next dividend bit into each partial remainder.
	assign ta = {ra_q, qa_q[LINE_BITS-1]};
	assign tb = {rb_q, qb_q[LINE_BITS-1]};

	// Control: count the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(LINE_BITS-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: compare and subtract in both lanes.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			qa_q  <= dividend_a;
			qb_q  <= dividend_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			if (ta >= {1'b0, dvs_q}) begin
				ra_q <= 5'(ta - {1'b0, dvs_q});
				qa_q <= {qa_q[LINE_BITS-2:0], 1'b1};
			end else begin
				ra_q <= ta[4:0];
				qa_q <= {qa_q[LINE_BITS-2:0], 1'b0};
			end
			if (tb >= {1'b0, dvs_q}) begin
				rb_q <= 5'(tb - {1'b0, dvs_q});
				qb_q <= {qb_q[LINE_BITS-2:0], 1'b1};
			end else begin
				rb_q <= tb[4:0];
				qb_q <= {qb_q[LINE_BITS-2:0], 1'b0};
			end
		end
	end

	assign res.done   = done_q;
	assign res.quot_a = qa_q;
	assign res.quot_b = qb_q;

endmodule

@@ rtl/core/pcd_take.sv @@
// Chunk arithmetic: takes a chunk from one partition entry and clips it.
// Depends on pcd_pkg for the entry and result structs.
module pcd_take import pcd_pkg::*; (
	input  part_ent_t            ent,
	input  logic [LINE_BITS-1:0] size,
	output take_res_t            res
);

	logic [LINE_BITS-1:0] size_eff;
	logic [LINE_BITS:0]   sum;
	logic                 clip;

	// A zero size counts as one line.
	assign size_eff = (size == '0) ? LINE_BITS'(1) : size;
	assign sum      = {1'b0, ent.next_line} + {1'b0, size_eff};
	assign clip     = sum >= {1'b0, ent.end_line};

	// The chunk ends at the partition end when it would reach past it.
	assign res.first    = ent.next_line;
	assign res.last     = clip ? LINE_BITS'(ent.end_line - 1'b1) : LINE_BITS'(sum - 1'b1);
	assign res.new_next = sum[LINE_BITS-1:0];
	assign res.clipped  = clip;

endmodule

@@ rtl/core/partitioned_chunk_dispatcher.sv @@
// Top level of the partitioned chunk dispatcher: register port, sequencer and stores.
// Depends on pcd_pkg, pcd_divider, pcd_take and assert_macros.svh.
//
//   channel  handshake                 payload
//   in       in_valid / in_stall       action, worker, message_kind, seq_slot, seq_chunk
//   out      out_valid / out_stall     command, first_line, last_line, partition
//   config   psel / penable / pready   paddr, pwrite, pwdata, prdata
//
// A start waits on the 16-step divider, then writes one partition entry per partition
// and one worker entry per worker to the stores. A worker message passes the worker
// store read and then the read-modify-write of the partition store; a move to another
// partition adds a scan of every partition of the job, and an exit found by the scan
// skips the write. Loads and refused items go straight to the result. Reset clears the
// control state and the configuration registers; the partition and worker stores hold
// nothing valid until a start writes them, and the size table until loads write it. A
// stalled result waits in the output register while the next item is accepted and worked on.
`include "assert_macros.svh"
module partitioned_chunk_dispatcher import pcd_pkg::*; #(
	parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [5:0]           worker,
	input  logic [1:0]           message_kind,
	input  logic [3:0]           seq_slot,
	input  logic [15:0]          seq_chunk,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           command,
	output logic [15:0]          first_line,
	output logic [15:0]          last_line,
	output logic [3:0]           partition
);

	localparam int WIDX = $clog2(MAX_WORKERS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_PART = 4'd2;
	localparam logic [3:0] ST_MAP  = 4'd3;
	localparam logic [3:0] ST_RDW  = 4'd4;
	localparam logic [3:0] ST_RDP  = 4'd5;
	localparam logic [3:0] ST_SCAN = 4'd6;
	localparam logic [3:0] ST_TAKE = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	// Configuration registers.
	logic [4:0]           num_partitions_q;
	logic [5:0]           num_workers_q;
	logic [LINE_BITS-1:0] image_height_q;
	logic [LINE_BITS-1:0] max_chunk_q;
	logic                 chunk_mode_q;
	logic [4:0]           sequence_length_q;
	logic                 cfg_we;

	// Control state.
	logic [3:0]           state_q;
	logic                 job_ready_q;
	logic [4:0]           job_parts_q;
	logic [5:0]           job_workers_q;
	logic [SEQ_BITS-1:0]  seq_pos_q;

	// Working registers.
	logic [5:0]           wk_q;
	logic [5:0]           w_q;
	logic [1:0]           kind_q;
	logic [PART_BITS-1:0] p_q;
	logic [PART_BITS-1:0] q_q;
	logic [LINE_BITS-1:0] share_q;
	logic [LINE_BITS-1:0] acc_q;
	logic [5:0]           group_q;
	logic [5:0]           cnt_q;
	logic [PART_BITS-1:0] g_q;
	logic [LINE_BITS-1:0] best_q;
	logic [PART_BITS-1:0] bestp_q;
	part_ent_t            bestent_q;
	part_ent_t            ent_q;
	logic [LINE_BITS-1:0] size_q;
	logic [2:0]           cmd_q;

	// Pending result and output register.
	logic [2:0]           res_cmd_q;
	logic [LINE_BITS-1:0] res_first_q, res_last_q;
	logic [PART_BITS-1:0] res_part_q;
	logic                 out_valid_q;
	logic [2:0]           out_cmd_q;
	logic [LINE_BITS-1:0] out_first_q, out_last_q;
	logic [PART_BITS-1:0] out_part_q;

	// Stores.
	part_ent_t            pm_mem [MAX_PARTITIONS];
	logic [PART_BITS-1:0] wp_mem [MAX_WORKERS];
	logic [LINE_BITS-1:0] sq_mem [SEQ_DEPTH];
	part_ent_t            pm_rdata, pm_wdata;
	logic [PART_BITS-1:0] pm_raddr, pm_waddr;
	logic                 pm_we;
	logic [PART_BITS-1:0] wp_rdata, wp_wdata;
	logic [WIDX-1:0]      wp_raddr, wp_waddr;
	logic                 wp_we;
	logic [LINE_BITS-1:0] sq_rdata;
	logic                 sq_we;

	// Combinational helpers.
	logic                 accept;
	logic [5:0]           wk_clamp;
	logic                 start_bad;
	logic [4:0]           seq_len;
	logic [4:0]           pos_inc;
	logic [SEQ_BITS-1:0]  pos_next;
	logic [LINE_BITS-1:0] part_end;
	logic                 part_last;
	logic [LINE_BITS-1:0] rem;
	logic                 cand;
	logic [LINE_BITS-1:0] best_n;
	logic [PART_BITS-1:0] bestp_n;
	part_ent_t            bestent_n;
	logic                 scan_last;
	div_res_t             div_res;
	take_res_t            take_res;
	logic                 out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// Register port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_partitions_q  <= 5'd1;
			num_workers_q     <= 6'd1;
			image_height_q    <= LINE_BITS'(1);
			max_chunk_q       <= LINE_BITS'(16);
			chunk_mode_q      <= 1'b0;
			sequence_length_q <= 5'd1;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_NUM_PARTITIONS:  num_partitions_q  <= pwdata[4:0];
				REG_NUM_WORKERS:     num_workers_q     <= pwdata[5:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= pwdata[LINE_BITS-1:0];
				REG_MAX_CHUNK:       max_chunk_q       <= pwdata[LINE_BITS-1:0];
				REG_CHUNK_MODE:      chunk_mode_q      <= pwdata[0];
				REG_SEQUENCE_LENGTH: sequence_length_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_NUM_PARTITIONS:  prdata = 32'(num_partitions_q);
			REG_NUM_WORKERS:     prdata = 32'(num_workers_q);
			REG_IMAGE_HEIGHT:    prdata = 32'(image_height_q);
			REG_MAX_CHUNK:       prdata = 32'(max_chunk_q);
			REG_CHUNK_MODE:      prdata = 32'(chunk_mode_q);
			REG_SEQUENCE_LENGTH: prdata = 32'(sequence_length_q);
			default:             prdata = '0;
		endcase
	end

	// Start checks and the worker count clamped to the last index of the worker store.
	assign start_bad = (num_partitions_q == '0) || (num_partitions_q > 5'(MAX_PARTITIONS)) ||
		(num_workers_q < {1'b0, num_partitions_q});
	assign wk_clamp  = (int'(num_workers_q) > MAX_WORKERS-1) ? 6'(MAX_WORKERS-1) : num_workers_q;

	// Next position of the cycling size sequence.
	assign seq_len  = (sequence_length_q == '0) ? 5'd1 :
		(sequence_length_q > 5'(SEQ_DEPTH)) ? 5'(SEQ_DEPTH) : sequence_length_q;
	assign pos_inc  = {1'b0, seq_pos_q} + 5'd1;
	assign pos_next = (pos_inc >= seq_len) ? '0 : pos_inc[SEQ_BITS-1:0];

	// Partition boundaries during the start sweep.
	assign part_last = {1'b0, p_q} == 5'(num_partitions_q - 1'b1);
	assign part_end  = part_last ? image_height_q : LINE_BITS'(acc_q + share_q);

	// Reassignment scan: keep the unexhausted partition with most lines left.
	assign rem       = LINE_BITS'(pm_rdata.end_line - pm_rdata.next_line);
	assign cand      = !pm_rdata.exhausted && (pm_rdata.end_line > pm_rdata.next_line) &&
		(rem > best_q);
	assign best_n    = cand ? rem : best_q;
	assign bestp_n   = cand ? q_q : bestp_q;
	assign bestent_n = cand ? pm_rdata : bestent_q;
	assign scan_last = {1'b0, q_q} == 5'(job_parts_q - 1'b1);

	pcd_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && action == ACT_START && !start_bad),
		.divisor    (num_partitions_q),
		.dividend_a (image_height_q),
		.dividend_b (LINE_BITS'(wk_clamp)),
		.res        (div_res)
	);

	pcd_take u_take (
		.ent  (ent_q),
		.size (size_q),
		.res  (take_res)
	);

	// Store addressing and write data.
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = p_q;
		pm_wdata = ent_q;
		pm_raddr = '0;
		wp_we    = 1'b0;
		wp_waddr = WIDX'(w_q);
		wp_wdata = g_q;
		wp_raddr = WIDX'(worker);
		sq_we    = accept && action == ACT_LOAD;
		case (state_q)
			ST_PART: begin
				pm_we              = 1'b1;
				pm_wdata.next_line = acc_q;
				pm_wdata.end_line  = part_end;
				pm_wdata.exhausted = acc_q >= part_end;
			end
			ST_MAP: begin
				wp_we = 1'b1;
			end
			ST_RDW: begin
				pm_raddr = wp_rdata;
			end
			ST_SCAN: begin
				pm_raddr = PART_BITS'(q_q + 1'b1);
				wp_we    = scan_last && best_n != '0;
				wp_wdata = bestp_n;
			end
			ST_TAKE: begin
				pm_we              = 1'b1;
				pm_wdata.next_line = take_res.clipped ? ent_q.next_line : take_res.new_next;
				pm_wdata.exhausted = take_res.clipped;
			end
			default: ;
		endcase
	end

	// Stores with registered reads.
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm_mem[pm_waddr] <= pm_wdata;
		end
		pm_rdata <= pm_mem[pm_raddr];
		if (wp_we) begin
			wp_mem[wp_waddr] <= wp_wdata;
		end
		wp_rdata <= wp_mem[wp_raddr];
		if (sq_we) begin
			sq_mem[seq_slot] <= seq_chunk;
		end
		sq_rdata <= sq_mem[pos_next];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			job_ready_q   <= 1'b0;
			job_parts_q   <= '0;
			job_workers_q <= '0;
			seq_pos_q     <= SEQ_BITS'(1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_START: begin
								if (start_bad) begin
									job_ready_q <= 1'b0;
									state_q     <= ST_FIN;
								end else begin
									state_q <= ST_DIV;
								end
							end
							ACT_LOAD: state_q <= ST_FIN;
							ACT_MSG: begin
								if (!job_ready_q || worker == '0 || worker > job_workers_q) begin
									state_q <= ST_FIN;
								end else if (message_kind[1]) begin
									job_ready_q <= 1'b0;
									state_q     <= ST_FIN;
								end else begin
									state_q <= ST_RDW;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_PART;
					end
				end
				ST_PART: begin
					if (part_last) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					if (w_q == wk_q) begin
						job_ready_q   <= 1'b1;
						job_parts_q   <= num_partitions_q;
						job_workers_q <= wk_q;
						seq_pos_q     <= SEQ_BITS'(1);
						state_q       <= ST_FIN;
					end
				end
				ST_RDW: state_q <= ST_RDP;
				ST_RDP: begin
					if (!pm_rdata.exhausted) begin
						if (chunk_mode_q) begin
							seq_pos_q <= pos_next;
						end
						state_q <= ST_TAKE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= (best_n == '0) ? ST_FIN : ST_TAKE;
					end
				end
				ST_TAKE: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_cmd_q   <= CMD_ERROR;
				res_first_q <= '0;
				res_last_q  <= '0;
				res_part_q  <= '0;
				w_q         <= worker;
				kind_q      <= message_kind;
				wk_q        <= wk_clamp;
				if (action == ACT_LOAD) begin
					res_cmd_q <= CMD_ACK;
				end
			end
			ST_DIV: begin
				share_q <= div_res.quot_a;
				group_q <= (div_res.quot_b[5:0] == '0) ? 6'd1 : div_res.quot_b[5:0];
				p_q     <= '0;
				acc_q   <= '0;
			end
			ST_PART: begin
				p_q   <= PART_BITS'(p_q + 1'b1);
				acc_q <= LINE_BITS'(acc_q + share_q);
				w_q   <= 6'd1;
				g_q   <= '0;
				cnt_q <= '0;
			end
			ST_MAP: begin
				res_cmd_q <= CMD_ACK;
				w_q       <= 6'(w_q + 1'b1);
				if (cnt_q == 6'(group_q - 1'b1)) begin
					cnt_q <= '0;
					if ({1'b0, g_q} < 5'(num_partitions_q - 1'b1)) begin
						g_q <= PART_BITS'(g_q + 1'b1);
					end
				end else begin
					cnt_q <= 6'(cnt_q + 1'b1);
				end
			end
			ST_RDW: begin
				p_q <= wp_rdata;
			end
			ST_RDP: begin
				ent_q   <= pm_rdata;
				size_q  <= chunk_mode_q ? sq_rdata : max_chunk_q;
				cmd_q   <= (kind_q == KIND_SETUP) ? CMD_SETUP : CMD_ASSIGN;
				q_q     <= '0;
				best_q  <= '0;
				bestp_q <= '0;
			end
			ST_SCAN: begin
				q_q       <= PART_BITS'(q_q + 1'b1);
				best_q    <= best_n;
				bestp_q   <= bestp_n;
				bestent_q <= bestent_n;
				ent_q     <= bestent_n;
				p_q       <= bestp_n;
				size_q    <= max_chunk_q;
				cmd_q     <= CMD_ASSIGN;
				res_cmd_q <= CMD_EXIT;
			end
			ST_TAKE: begin
				res_cmd_q   <= cmd_q;
				res_first_q <= take_res.first;
				res_last_q  <= take_res.last;
				res_part_q  <= p_q;
			end
			default: ;
		endcase
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_cmd_q   <= res_cmd_q;
			out_first_q <= res_first_q;
			out_last_q  <= res_last_q;
			out_part_q  <= res_part_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign command    = out_cmd_q;
	assign first_line = out_first_q;
	assign last_line  = out_last_q;
	assign partition  = out_part_q;

	// Results without a chunk carry zero fields.
	`AST_IMPL(a_zero_fields, out_valid && (command == CMD_EXIT || command == CMD_ERROR || command == CMD_ACK), first_line == '0 && last_line == '0 && partition == '0, "non-chunk result with fields set")
	// A handed-out chunk never runs backwards.
	`AST_IMPL(a_chunk_order, out_valid && (command == CMD_ASSIGN || command == CMD_SETUP), last_line >= first_line, "chunk ends before it starts")
	// The divider reports only while the sequencer waits for it.
	`AST_IMPL(a_div_state, div_res.done, state_q == ST_DIV, "divider finished outside the start sweep")
	// An accepted item always leaves the idle state.
	`AST_NEXT(a_leave_idle, accept, state_q != ST_IDLE, "accepted item not taken up")

endmodule

@@ bench/tb_partitioned_chunk_dispatcher.sv @@
// Testbench of the partitioned chunk dispatcher: directed and random items, checked by a predictor.
// Depends on pcd_pkg and the partitioned_chunk_dispatcher RTL.
`timescale 1ns / 1ps
module tb_partitioned_chunk_dispatcher;
	import pcd_pkg::*;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] first;
		logic [15:0] last;
		logic [3:0]  part;
	} dispatch_t;

	logic        clk, arst_n;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0, in_stall;
	logic [1:0]  action = '0;
	logic [5:0]  worker = '0;
	logic [1:0]  message_kind = '0;
	logic [3:0]  seq_slot = '0;
	logic [15:0] seq_chunk = '0;
	logic        out_valid, out_stall = 0;
	logic [2:0]  command;
	logic [15:0] first_line, last_line;
	logic [3:0]  partition;

	partitioned_chunk_dispatcher dut (.*);

	// Predictor copy of the registers and the job state.
	int unsigned cfg_parts = 1, cfg_workers = 1, cfg_height = 1, cfg_chunk = 16;
	int unsigned cfg_mode = 0, cfg_seq_len = 1;
	int unsigned line_next [MAX_PARTITIONS];
	int unsigned line_end [MAX_PARTITIONS];
	bit          part_done [MAX_PARTITIONS];
	int unsigned worker_part [64];
	int unsigned size_table [SEQ_DEPTH];
	int unsigned size_pos = 1;
	bit          job_open = 0;
	int unsigned job_parts = 0, job_workers = 0;

	dispatch_t expected_cmds [$];
	int errors = 0, items_sent = 0, results_seen = 0, chunks_seen = 0, exits_seen = 0;
	int send_idle = 0, recv_idle = 0, hold_req = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		#5ms;
		$display("partitioned_chunk_dispatcher: mismatch");
		$finish;
	end

	// Receiver: a long hold-off when asked, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1;
			hold_req--;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		dispatch_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {command, first_line, last_line, partition};
			results_seen++;
			if (command == CMD_EXIT) exits_seen++;
			if (command == CMD_ASSIGN || command == CMD_SETUP) chunks_seen++;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want) begin
					$display("%0t: expected cmd %0d lines %0d..%0d part %0d, got cmd %0d lines %0d..%0d part %0d",
						$time, want.cmd, want.first, want.last, want.part,
						got.cmd, got.first, got.last, got.part);
					errors++;
				end
			end
		end
	end

	// Hand out a chunk from partition p, clipping at its end.
	function automatic void take_lines(int unsigned p, int unsigned size, output dispatch_t r);
		int unsigned lo, fin;
		lo = line_next[p];
		if (size == 0) size = 1;
		fin = lo + size - 1;
		if (fin + 1 >= line_end[p]) begin
			fin = line_end[p] - 1;
			part_done[p] = 1;
		end else
			line_next[p] = (lo + size) & 16'hFFFF;
		r.first = lo[15:0];
		r.last  = fin[15:0];
		r.part  = p[3:0];
	endfunction

	function automatic int unsigned next_table_size();
		int unsigned len;
		len = cfg_seq_len;
		if (len == 0) len = 1;
		if (len > SEQ_DEPTH) len = SEQ_DEPTH;
		size_pos++;
		if (size_pos >= len) size_pos = 0;
		return size_table[size_pos % SEQ_DEPTH];
	endfunction

	// Works out the command that one accepted item should cause.
	function automatic dispatch_t predict_dispatch(logic [1:0] act, logic [5:0] w,
			logic [1:0] kind, logic [3:0] slot, logic [15:0] chunk);
		dispatch_t r;
		int unsigned share, group, g, p, best, sz;
		r = '0;
		r.cmd = CMD_ERROR;
		if (act == ACT_START) begin
			if (cfg_parts == 0 || cfg_parts > MAX_PARTITIONS || cfg_workers < cfg_parts) begin
				job_open = 0;
				return r;
			end
			share = cfg_height / cfg_parts;
			for (int q = 0; q < cfg_parts; q++) begin
				line_next[q] = (q * share) & 16'hFFFF;
				line_end[q] = (q + 1 == cfg_parts) ? cfg_height : ((q + 1) * share) & 16'hFFFF;
				part_done[q] = line_next[q] >= line_end[q];
			end
			group = cfg_workers / cfg_parts;
			if (group == 0) group = 1;
			for (int v = 1; v <= cfg_workers; v++) begin
				g = (v - 1) / group;
				worker_part[v] = (g > cfg_parts - 1) ? cfg_parts - 1 : g;
			end
			job_parts = cfg_parts;
			job_workers = cfg_workers;
			size_pos = 1;
			job_open = 1;
			r.cmd = CMD_ACK;
		end else if (act == ACT_LOAD) begin
			size_table[slot] = chunk;
			r.cmd = CMD_ACK;
		end else if (act == ACT_MSG) begin
			if (!job_open || w == 0 || w > job_workers) return r;
			if (kind >= 2) begin
				job_open = 0;
				return r;
			end
			p = worker_part[w] % MAX_PARTITIONS;
			if (!part_done[p]) begin
				sz = cfg_mode ? next_table_size() : cfg_chunk;
				take_lines(p, sz, r);
				r.cmd = (kind == KIND_SETUP) ? CMD_SETUP : CMD_ASSIGN;
				return r;
			end
			// Exhausted: move to the open partition with the most lines left.
			best = 0;
			for (int q = 0; q < job_parts; q++)
				if (!part_done[q] && line_end[q] > line_next[q] && line_end[q] - line_next[q] > best) begin
					best = line_end[q] - line_next[q];
					p = q;
				end
			if (best == 0) begin
				r.cmd = CMD_EXIT;
				return r;
			end
			worker_part[w] = p;
			take_lines(p, cfg_chunk, r);
			r.cmd = CMD_ASSIGN;
		end
		return r;
	endfunction

	// Offer one item, with random gaps, and record its expectation on acceptance.
	task automatic send_item(logic [1:0] act, logic [5:0] w, logic [1:0] kind,
			logic [3:0] slot, logic [15:0] chunk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		worker <= w;
		message_kind <= kind;
		seq_slot <= slot;
		seq_chunk <= chunk;
		do @(posedge clk); while (in_stall);
		expected_cmds.push_back(predict_dispatch(act, w, kind, slot, chunk));
		items_sent++;
	endtask

	task automatic send_start();
		send_item(ACT_START, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_msg(logic [5:0] w, logic [1:0] kind);
		send_item(ACT_MSG, w, kind, $urandom, $urandom);
	endtask

	// Wait for every expected result, then let the block settle.
	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (expected_cmds.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// One register write: setup phase, access phase, then an idle phase on the port.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
		case (idx)
			REG_NUM_PARTITIONS:  cfg_parts = val & 32'h1F;
			REG_NUM_WORKERS:     cfg_workers = val & 32'h3F;
			REG_IMAGE_HEIGHT:    cfg_height = val & 32'hFFFF;
			REG_MAX_CHUNK:       cfg_chunk = val & 32'hFFFF;
			REG_CHUNK_MODE:      cfg_mode = val & 32'h1;
			REG_SEQUENCE_LENGTH: cfg_seq_len = val & 32'h1F;
			default: ;
		endcase
	endtask

	task automatic configure(int np, int nw, int h, int mc, int mode, int sl);
		drain();
		reg_write(REG_NUM_PARTITIONS, np);
		reg_write(REG_NUM_WORKERS, nw);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_MAX_CHUNK, mc);
		reg_write(REG_CHUNK_MODE, mode);
		reg_write(REG_SEQUENCE_LENGTH, sl);
	endtask

	// Messages before any job and the unused action are refused.
	task automatic test_no_job();
		send_msg(1, KIND_SETUP);
		send_item(2'd3, 6'h3F, 2'd3, 4'hF, 16'hFFFF);
	endtask

	// Fill the whole size table so that every later read finds a loaded slot.
	task automatic test_table_load();
		for (int s = 0; s < SEQ_DEPTH; s++)
			send_item(ACT_LOAD, 0, 0, s, (s == 0) ? 16'd0 : (s == 15) ? 16'hFFFF : s * 3);
	endtask

	// Starts refused for zero partitions, too many partitions or too few workers.
	task automatic test_refused_starts();
		configure(0, 4, 100, 16, 0, 1);
		send_start();
		configure(20, 63, 100, 16, 0, 1);
		send_start();
		configure(8, 3, 100, 16, 0, 1);
		send_start();
		send_msg(1, KIND_FINISH);
	endtask

	// A small job: last partition takes the rest, unknown workers, error ends the job.
	task automatic test_small_job();
		configure(4, 5, 10, 3, 0, 1);
		send_start();
		for (int w = 1; w <= 5; w++) send_msg(w, KIND_SETUP);
		send_msg(0, KIND_FINISH);
		send_msg(6, KIND_FINISH);
		repeat (6) send_msg(1, KIND_FINISH);
		send_msg(2, 2'd3);
		send_msg(2, KIND_FINISH);
	endtask

	// Empty partitions, zero chunk size, the table mode and the largest sizes.
	task automatic test_extremes();
		configure(8, 8, 3, 0, 0, 0);
		send_start();
		repeat (5) send_msg($urandom_range(1, 8), KIND_FINISH);
		configure(16, 63, 65535, 65535, 1, 31);
		send_start();
		send_msg(63, KIND_SETUP);
		send_msg(1, KIND_SETUP);
		send_msg(1, KIND_FINISH);
		send_msg(1, KIND_FINISH);
	endtask

	// The receiver holds off a long while so that the block backs up.
	task automatic test_backpressure();
		configure(2, 4, 200, 5, 0, 1);
		send_start();
		hold_req = 300;
		repeat (20) send_msg($urandom_range(1, 4), $urandom_range(0, 1));
	endtask

	// Random jobs: mostly well-formed messages, with noise and broken sequences.
	task automatic test_random(int n);
		int np, r;
		np = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 16);
		if ($urandom_range(5) == 0)
			configure(np, $urandom_range(np, 63), $urandom_range(1000, 65535),
				$urandom_range(2000, 65535), $urandom_range(1), $urandom_range(31));
		else
			configure(np, $urandom_range(np, 63), $urandom_range(1, 300),
				$urandom_range(0, 40), $urandom_range(1), $urandom_range(31));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (!job_open || r >= 97) send_start();
			else if (r < 80) send_msg($urandom_range(1, job_workers), $urandom_range(0, 1));
			else if (r < 86) send_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
			else if (r < 91) send_msg((job_workers < 63 && r[0]) ? $urandom_range(job_workers + 1, 63) : 0,
				$urandom);
			else if (r < 94) send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
			else send_msg($urandom_range(1, job_workers), $urandom_range(2, 3));
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		test_no_job();
		test_table_load();
		test_refused_starts();
		test_small_job();
		test_extremes();
		test_backpressure();
		send_idle = 10;
		recv_idle = 75;
		repeat (3) test_random(40);
		send_idle = 75;
		recv_idle = 10;
		repeat (3) test_random(40);
		send_idle = 0;
		recv_idle = 0;
		repeat (3) test_random(40);
		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d items; checked %0d results, %0d of them chunks and %0d exits.",
			items_sent, results_seen, chunks_seen, exits_seen);
		$display("Covered refused starts, empty partitions, table sizes and reassignment.");
		if (errors == 0 && expected_cmds.size() == 0)
			$display("partitioned_chunk_dispatcher: match");
		else
			$display("partitioned_chunk_dispatcher: mismatch");
		$finish;
	end

endmodule
